// File: src/mte_pkg.sv
// ----------------------------------------------------------------------------
// MIDI track event encoder package
// Shared constants and the command record passed from front to back end.
// ----------------------------------------------------------------------------
package mte_pkg;

	localparam int KEY_COUNT = 128;
	localparam int KEY_W     = $clog2(KEY_COUNT);
	localparam int TICK_W    = 32;
	localparam int DELTA_W   = 28;

	localparam logic [TICK_W-1:0] MAX_DELTA = 32'h0fff_ffff;

	localparam logic [7:0] STAT_NOTE_ON  = 8'h90;
	localparam logic [7:0] STAT_NOTE_OFF = 8'h80;
	localparam logic [7:0] VEL_ON        = 8'd64;
	localparam logic [7:0] VEL_OFF       = 8'd0;
	localparam logic [7:0] META_BYTE     = 8'hff;
	localparam logic [7:0] META_EOT      = 8'h2f;
	localparam logic [7:0] META_LEN0     = 8'h00;
	localparam logic [3:0] PERC_CHANNEL  = 4'd9;

	localparam logic       ACT_EDGE = 1'b0;
	localparam logic       ACT_END  = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_OVERLAP = 2'd1;
	localparam logic [1:0] ST_DELTA   = 2'd2;

	// One encoded event, or one error report.
	typedef struct packed {
		logic               err;
		logic [1:0]         code;
		logic [1:0]         vlq_last;   // number of delta bytes minus one
		logic [DELTA_W-1:0] delta;
		logic [7:0]         tail0;
		logic [7:0]         tail1;
		logic [7:0]         tail2;
	} cmd_t;

endpackage

// File: src/mte_front.sv
// ----------------------------------------------------------------------------
// MIDI track event encoder front end
// Checks each edge against the key map and last tick, updates the track
// state and turns the beat into a command for the byte serialiser.
// ----------------------------------------------------------------------------
module mte_front import mte_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [3:0]        cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_action,
	input  logic [TICK_W-1:0] in_tick,
	input  logic              in_note_on,
	input  logic [KEY_W-1:0]  in_key,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output cmd_t              cmd
);

	logic [3:0]          track_q;
	logic                key_mem_q [KEY_COUNT];
	logic [TICK_W-1:0]   last_tick_q;
	logic                failed_q;
	logic [1:0]          fail_code_q;
	logic                clr_busy_q;
	logic [KEY_W-1:0]    clr_addr_q;

	logic                valid_s1;
	logic                action_s1;
	logic [TICK_W-1:0]   tick_s1;
	logic                note_on_s1;
	logic [KEY_W-1:0]    key_s1;
	logic                key_rd_s1;

	logic [3:0]          chan_base;
	logic [3:0]          channel;
	logic [TICK_W:0]     diff;
	logic                tick_after;
	logic [TICK_W-1:0]   end_delta;
	logic [TICK_W-1:0]   sel_delta;
	logic                overlap;
	logic                edge_bad_delta;
	logic                accept;
	logic                advance;
	logic                do_clear;
	logic                do_fail;
	logic                do_update;

	// An end beat holds the input off until the key map has been swept clean.
	assign cfg_ready = 1'b1;
	assign in_ready  = !clr_busy_q && (!valid_s1 || (cmd_ready && action_s1 == ACT_EDGE));
	assign cmd_valid = valid_s1;
	assign accept    = in_valid && in_ready;
	assign advance   = valid_s1 && cmd_ready;

	// Channel is track minus one, stepping over the percussion channel.
	always_comb begin
		chan_base = (track_q == 4'd0) ? 4'd0 : track_q - 4'd1;
		channel   = (chan_base >= PERC_CHANNEL) ? chan_base + 4'd1 : chan_base;
	end

	assign diff           = {1'b0, tick_s1} - {1'b0, last_tick_q};
	assign tick_after     = !diff[TICK_W] && (diff[TICK_W-1:0] != '0);
	assign end_delta      = tick_after ? diff[TICK_W-1:0] : '0;
	assign overlap        = (note_on_s1 == key_rd_s1);
	assign edge_bad_delta = diff[TICK_W] || (diff[TICK_W-1:0] > MAX_DELTA);
	assign sel_delta      = (action_s1 == ACT_END) ? end_delta : diff[TICK_W-1:0];

	always_comb begin
		cmd          = '0;
		do_clear     = 1'b0;
		do_fail      = 1'b0;
		do_update    = 1'b0;
		cmd.delta    = sel_delta[DELTA_W-1:0];
		if (sel_delta[DELTA_W-1:21] != '0) begin
			cmd.vlq_last = 2'd3;
		end else if (sel_delta[20:14] != '0) begin
			cmd.vlq_last = 2'd2;
		end else if (sel_delta[13:7] != '0) begin
			cmd.vlq_last = 2'd1;
		end else begin
			cmd.vlq_last = 2'd0;
		end
		if (action_s1 == ACT_END) begin
			do_clear  = 1'b1;
			cmd.tail0 = META_BYTE;
			cmd.tail1 = META_EOT;
			cmd.tail2 = META_LEN0;
			if (failed_q) begin
				cmd.err  = 1'b1;
				cmd.code = fail_code_q;
			end else if (end_delta > MAX_DELTA) begin
				cmd.err  = 1'b1;
				cmd.code = ST_DELTA;
			end
		end else begin
			cmd.tail0 = (note_on_s1 ? STAT_NOTE_ON : STAT_NOTE_OFF) | {4'd0, channel};
			cmd.tail1 = {1'b0, key_s1};
			cmd.tail2 = note_on_s1 ? VEL_ON : VEL_OFF;
			if (failed_q) begin
				cmd.err  = 1'b1;
				cmd.code = fail_code_q;
			end else if (overlap) begin
				cmd.err  = 1'b1;
				cmd.code = ST_OVERLAP;
				do_fail  = 1'b1;
			end else if (edge_bad_delta) begin
				cmd.err  = 1'b1;
				cmd.code = ST_DELTA;
				do_fail  = 1'b1;
			end else begin
				do_update = 1'b1;
			end
		end
	end

	// Key map and the accepted beat. A key written by the beat leaving the
	// stage is forwarded to a beat arriving in the same cycle.
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			key_mem_q[clr_addr_q] <= 1'b0;
		end else if (advance && do_update) begin
			key_mem_q[key_s1] <= note_on_s1;
		end
		if (accept) begin
			action_s1  <= in_action;
			tick_s1    <= in_tick;
			note_on_s1 <= in_note_on;
			key_s1     <= in_key;
			key_rd_s1  <= (advance && do_update && key_s1 == in_key) ?
				note_on_s1 : key_mem_q[in_key];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q      <= 4'd1;
			last_tick_q  <= '0;
			failed_q     <= 1'b0;
			fail_code_q  <= ST_OK;
			clr_busy_q   <= 1'b1;
			clr_addr_q   <= '0;
			valid_s1     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				track_q <= cfg_data;
			end
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + KEY_W'(1);
				if (clr_addr_q == KEY_W'(KEY_COUNT - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end else if (advance && do_clear) begin
				clr_busy_q <= 1'b1;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				if (do_clear) begin
					last_tick_q  <= '0;
					failed_q     <= 1'b0;
					fail_code_q  <= ST_OK;
				end else if (do_fail) begin
					failed_q    <= 1'b1;
					fail_code_q <= cmd.code;
				end else if (do_update) begin
					last_tick_q <= tick_s1;
				end
			end
		end
	end

endmodule

// File: src/mte_queue.sv
// ----------------------------------------------------------------------------
// MIDI track event encoder command queue
// Two-entry queue between the front end and the byte serialiser.
// ----------------------------------------------------------------------------
module mte_queue import mte_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  cmd_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output cmd_t rd_data
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: src/mte_back.sv
// ----------------------------------------------------------------------------
// MIDI track event encoder back end
// Serialises one command into its delta bytes and three event bytes (an error
// report into one beat), one byte per cycle unless out_ready stalls, into registered beats.
// ----------------------------------------------------------------------------
module mte_back import mte_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  cmd_t       cmd,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] out_status,
	output logic       out_last
);

	logic [2:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic [1:0] status_q;
	logic       last_q;

	logic       load;
	logic [2:0] final_idx;
	logic       in_vlq;
	logic [1:0] group;
	logic [1:0] tail_idx;
	logic [2:0] tail_sub;
	logic [7:0] next_byte;
	logic       next_last;

	assign load      = cmd_valid && (!valid_q || out_ready);
	assign final_idx = {1'b0, cmd.vlq_last} + 3'd3;
	assign in_vlq    = (idx_q <= {1'b0, cmd.vlq_last});
	assign group     = cmd.vlq_last - idx_q[1:0];
	assign tail_sub  = idx_q - {1'b0, cmd.vlq_last} - 3'd1;
	assign tail_idx  = tail_sub[1:0];
	assign next_last = cmd.err || (idx_q == final_idx);
	assign cmd_ready = load && next_last;

	always_comb begin
		next_byte = 8'd0;
		if (cmd.err) begin
			next_byte = 8'd0;
		end else if (in_vlq) begin
			// Most significant group first; all but the lowest carry bit seven.
			case (group)
				2'd0:    next_byte = {1'b0, cmd.delta[6:0]};
				2'd1:    next_byte = {1'b1, cmd.delta[13:7]};
				2'd2:    next_byte = {1'b1, cmd.delta[20:14]};
				2'd3:    next_byte = {1'b1, cmd.delta[27:21]};
				default: next_byte = 8'd0;
			endcase
		end else begin
			case (tail_idx)
				2'd0:    next_byte = cmd.tail0;
				2'd1:    next_byte = cmd.tail1;
				2'd2:    next_byte = cmd.tail2;
				default: next_byte = 8'd0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= next_byte;
			status_q <= cmd.err ? cmd.code : ST_OK;
			last_q   <= next_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 3'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= next_last ? 3'd0 : idx_q + 3'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = valid_q;
	assign out_byte   = byte_q;
	assign out_status = status_q;
	assign out_last   = last_q;

endmodule

// File: src/midi_track_event_encoder_top.sv
// ----------------------------------------------------------------------------
// MIDI track event encoder
// Encodes sorted note edges and end-of-track requests into MIDI track bytes.
// ----------------------------------------------------------------------------
//  Channel   Direction  Content
//  s_*       in         note edge or end request (tuser: action)
//  m_*       out        one event byte per beat (tuser: status, tlast: last)
//  cfg_*     in         track number
//
// An edge or end request yields its delta bytes plus three event bytes, 4 to 7
// beats, one byte per cycle unless m_tready stalls; an error report is one beat.
// The front end takes one beat per cycle while the queue has room and no sweep
// runs, and holds each accepted beat in a register before it enters the queue.
// After reset the key map is swept one entry per cycle, holding the input off
// until all 128 entries are clear; an end beat holds it off until its sweep ends.
// Either side may stall; the two-entry queue and output register decouple them.
module midi_track_event_encoder_top import mte_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,   // track_number
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,    // tick[31:0], note_on[32], key[39:33]
	input  logic        s_tuser,    // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // out_byte[7:0]
	output logic [1:0]  m_tuser,    // status[1:0]
	output logic        m_tlast
);

	logic fq_valid;
	logic fq_ready;
	cmd_t fq_cmd;
	logic qb_valid;
	logic qb_ready;
	cmd_t qb_cmd;

	mte_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_action  (s_tuser),
		.in_tick    (s_tdata[31:0]),
		.in_note_on (s_tdata[32]),
		.in_key     (s_tdata[39:33]),
		.cmd_valid  (fq_valid),
		.cmd_ready  (fq_ready),
		.cmd        (fq_cmd)
	);

	mte_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_data  (fq_cmd),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready),
		.rd_data  (qb_cmd)
	);

	mte_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (qb_valid),
		.cmd_ready  (qb_ready),
		.cmd        (qb_cmd),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (m_tdata),
		.out_status (m_tuser),
		.out_last   (m_tlast)
	);

endmodule
